// File: sv/maes_pkg.sv
`default_nettype none
package maes_pkg;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned KEY_WORDS = 4 * (ROUNDS + 1);
  localparam int unsigned BUILD_CYCLES = KEY_WORDS - 3;
  localparam int unsigned BUILD_W = $clog2(BUILD_CYCLES + 1);

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_MASK     = 2'd2;

  localparam logic [7:0]  REDUCE_POLY = 8'h1b;
  localparam logic [31:0] RCON_FIRST  = 32'h0100_0000;

  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } pt_t;

  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } ct_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      o[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
    end
    return o;
  endfunction

  function automatic logic [7:0] sbox_m(input logic [7:0] x, input logic [7:0] m,
                                        input logic [7:0] mp);
    return SBOX[x ^ m] ^ mp;
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic [7:0] m,
                                             input logic [7:0] mp);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = sbox_m(s[127-8*(4*((c+r)%4)+r) -: 8], m, mp);
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

// File: sv/masked_aes128_block_encrypt_unit.sv
// A result is shown for one cycle, together with the done strobe.
// Throughput: one block per cycle while busy is low, one pipeline stage per round plus the whitening stage.
// After reset and after each write to a key or mask register, busy stays high
// while the round keys are expanded one word per cycle; no start is taken meanwhile.
// Reset is asynchronous and clears the key and mask registers, the stage valid bits and starts expansion.
`default_nettype none
module masked_aes128_block_encrypt_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire maes_pkg::pt_t     plaintext_i,
  output      logic              done_o,
  output      maes_pkg::ct_t     ciphertext_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i
);
  import maes_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic [47:0] mask_q;
  logic [31:0] rk_q [KEY_WORDS];
  logic [31:0] rc_q;
  logic [1:0]  ph_q;
  logic [BUILD_W-1:0] cnt_q;
  logic [127:0] st_q [ROUNDS+1];
  logic [ROUNDS:0] vld_q;

  logic [7:0]   m, mp;
  logic [31:0]  mc, kmask;
  logic [31:0]  t_w, new_w;
  logic         cfg_hit;
  logic [127:0] st_d [ROUNDS+1];

  assign m       = mask_q[47:40];
  assign mp      = mask_q[39:32];
  assign mc      = mix_col(mask_q[31:0]);
  assign kmask   = {4{m}} ^ mc;
  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CFG_KEY_HIGH, CFG_KEY_LOW, CFG_MASK});
  assign busy    = cnt_q != '0;

  always_comb begin
    t_w = rk_q[KEY_WORDS-1];
    if (ph_q == 2'd0) begin
      t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ rc_q;
    end
    new_w = rk_q[KEY_WORDS-4] ^ t_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      mask_q   <= '0;
      cnt_q    <= BUILD_W'(BUILD_CYCLES);
      ph_q     <= '0;
      rc_q     <= RCON_FIRST;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_KEY_LOW)  key_lo_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_MASK)     mask_q   <= cfg_data_i[47:0];
      if (cfg_hit) begin
        cnt_q <= BUILD_W'(BUILD_CYCLES);
      end else if (cnt_q == BUILD_W'(BUILD_CYCLES)) begin
        cnt_q <= cnt_q - 1'b1;
        ph_q  <= '0;
        rc_q  <= RCON_FIRST;
      end else if (busy) begin
        cnt_q <= cnt_q - 1'b1;
        ph_q  <= ph_q + 1'b1;
        if (ph_q == 2'd0) rc_q <= {xtime(rc_q[31:24]), 24'd0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cfg_hit && cnt_q == BUILD_W'(BUILD_CYCLES)) begin
      rk_q[KEY_WORDS-4] <= key_hi_q[63:32];
      rk_q[KEY_WORDS-3] <= key_hi_q[31:0];
      rk_q[KEY_WORDS-2] <= key_lo_q[63:32];
      rk_q[KEY_WORDS-1] <= key_lo_q[31:0];
    end else if (!cfg_hit && busy) begin
      for (int j = 0; j < KEY_WORDS - 1; j++) begin
        rk_q[j] <= rk_q[j+1];
      end
      rk_q[KEY_WORDS-1] <= new_w;
    end
  end

  always_comb begin
    st_d[0] = {plaintext_i.plaintext_high, plaintext_i.plaintext_low} ^ {4{mc}} ^
              ({rk_q[0], rk_q[1], rk_q[2], rk_q[3]} ^ {4{kmask}});
    for (int r = 1; r <= ROUNDS; r++) begin
      st_d[r] = sub_shift(st_q[r-1], m, mp);
      if (r != ROUNDS) begin
        st_d[r] = mix_all(st_d[r] ^ {4{mask_q[31:0] ^ {4{mp}}}});
      end
      st_d[r] = st_d[r] ^ {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]} ^ {4{kmask}};
      if (r == ROUNDS) begin
        st_d[r] = st_d[r] ^ {4{{4{m ^ mp}} ^ mc}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ROUNDS-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r <= ROUNDS; r++) begin
      st_q[r] <= st_d[r];
    end
  end

  assign done_o       = vld_q[ROUNDS];
  assign ciphertext_o = st_q[ROUNDS];

endmodule
`default_nettype wire

// File: sv/maes_checker.sv
`default_nettype none
module maes_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic       cfg_we_i,
  input wire logic [1:0] cfg_idx_i
);
  import maes_pkg::*;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##11 done_o) else $error("missing done");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 11)) else $error("spurious done");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW ||
                  cfg_idx_i == CFG_MASK)) |=> busy) else $error("no rebuild");

endmodule

bind masked_aes128_block_encrypt_unit maes_checker u_maes_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i)
);
`default_nettype wire
